FILE: rtl/assert_macros.svh
// assertion macros for the rtl files
// no dependencies; included by modules that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define VFC_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every rising edge outside reset
`define VFC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/vfc_pkg.sv
// shared types and constants for the value frequency counter
// no dependencies; imported by front, back and top level
package vfc_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int MAX_RESULTS = 64;
    localparam int Q_DEPTH     = 2;
    localparam int Q_AW        = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_TOPK  = 2'd1,
        CMD_WIN   = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    // classified request handed from front to back
    typedef struct packed {
        t_cmd        cmd;
        logic [63:0] label;
        logic [6:0]  top_k;
        logic        nan;
        logic        zero;
    } t_req;

    function automatic logic is_nan(input logic [63:0] v);
        return (&v[62:52]) && (|v[51:0]);
    endfunction

    function automatic logic is_zero(input logic [63:0] v);
        return ~|v[62:0];
    endfunction

endpackage

FILE: rtl/vfc_front.sv
// front end: accepts input words, classifies them and queues requests
// depends on vfc_pkg
module vfc_front import vfc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [63:0] i_label,
    input  logic [6:0]  i_top_k,
    output t_req        o_req,
    output logic        o_req_valid,
    input  logic        i_req_pop
);

    t_req              r_q [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp, r_rp;
    logic [Q_AW:0]     r_cnt;
    logic              push;
    t_req              n_req;

    assign o_stall     = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign push        = i_valid && !o_stall;
    assign o_req_valid = (r_cnt != '0);
    assign o_req       = r_q[r_rp];

    always_comb begin
        n_req.cmd   = t_cmd'(i_cmd);
        n_req.label = i_label;
        n_req.top_k = i_top_k;
        n_req.nan   = is_nan(i_label);
        n_req.zero  = is_zero(i_label);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_req;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == Q_AW'(Q_DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (i_req_pop) begin
                r_rp <= (r_rp == Q_AW'(Q_DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            case ({push, i_req_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: rtl/vfc_back.sv
// back end: table memories and the walk engine for add, top k, winner, clear
// depends on vfc_pkg and assert_macros.svh
`include "assert_macros.svh"
module vfc_back import vfc_pkg::*; #(
    parameter int DEPTH = TABLE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_req        i_req,
    input  logic        i_req_valid,
    output logic        o_req_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_out_label,
    output logic [31:0] o_out_count,
    output logic [6:0]  o_winners,
    output logic [1:0]  o_status,
    output logic        o_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_FETCH = 5'b00100,
        S_LOAD  = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state        r_state;
    logic [63:0]   r_lbl_mem [DEPTH];
    logic [31:0]   r_cnt_mem [DEPTH];
    logic [63:0]   r_lbl_rd;
    logic [31:0]   r_cnt_rd;

    t_cmd          r_op;
    logic [63:0]   r_label;
    logic          r_lnan, r_lzero;
    logic [CW-1:0] r_n, r_ptr;
    logic          r_pv;
    logic [AW-1:0] r_pidx;
    logic [6:0]    r_k, r_emit, r_win;
    logic          r_first, r_bfound;
    logic [31:0]   r_pcnt, r_bcnt, r_best;
    logic [AW-1:0] r_lidx, r_bidx;

    logic [63:0]   r_o_label;
    logic [31:0]   r_o_count;
    logic [6:0]    r_o_win;
    t_status       r_o_status;
    logic          r_o_last;

    logic [AW-1:0] rd_addr, wr_addr;
    logic          issue, scan_done, st_nan, st_zero, match, hit, append;
    logic          eligible, better, we_cnt;
    logic [31:0]   cnt_inc, wr_cnt;
    logic [6:0]    k_eff;

    assign issue     = (r_state == S_SCAN) && (r_ptr < r_n);
    assign scan_done = (r_state == S_SCAN) && !r_pv && !issue;
    assign rd_addr   = (r_state == S_FETCH) ? r_bidx : r_ptr[AW-1:0];

    assign st_nan  = is_nan(r_lbl_rd);
    assign st_zero = is_zero(r_lbl_rd);
    assign match   = !st_nan && !r_lnan && ((st_zero && r_lzero) || (r_lbl_rd == r_label));
    assign hit     = (r_state == S_SCAN) && r_pv && (r_op == CMD_ADD) && match;
    assign append  = scan_done && (r_op == CMD_ADD) && (r_n != CW'(DEPTH));
    assign cnt_inc = (&r_cnt_rd) ? r_cnt_rd : r_cnt_rd + 32'd1;
    assign we_cnt  = hit || append;
    assign wr_addr = hit ? r_pidx : r_n[AW-1:0];
    assign wr_cnt  = hit ? cnt_inc : 32'd1;

    // next entry in (count desc, index asc) order after the last one sent
    assign eligible = r_first || (r_cnt_rd < r_pcnt)
                    || ((r_cnt_rd == r_pcnt) && (r_pidx > r_lidx));
    assign better   = eligible && (!r_bfound || (r_cnt_rd > r_bcnt));

    always_comb begin
        int kk;
        kk = int'(i_req.top_k);
        if (kk > int'(r_n)) kk = int'(r_n);
        if (kk > MAX_RESULTS) kk = MAX_RESULTS;
        k_eff = 7'(kk);
    end

    assign o_req_pop   = (r_state == S_IDLE) && i_req_valid;
    assign o_valid     = (r_state == S_OUT);
    assign o_out_label = r_o_label;
    assign o_out_count = r_o_count;
    assign o_winners   = r_o_win;
    assign o_status    = r_o_status;
    assign o_last      = r_o_last;

    always_ff @(posedge i_clk) begin
        r_lbl_rd <= r_lbl_mem[rd_addr];
        r_cnt_rd <= r_cnt_mem[rd_addr];
        if (we_cnt) begin
            r_cnt_mem[wr_addr] <= wr_cnt;
        end
        if (append) begin
            r_lbl_mem[wr_addr] <= r_label;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n     <= '0;
            r_pv    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_op      <= i_req.cmd;
                        r_label   <= i_req.label;
                        r_lnan    <= i_req.nan;
                        r_lzero   <= i_req.zero;
                        r_ptr     <= '0;
                        r_pv      <= 1'b0;
                        r_first   <= 1'b1;
                        r_bfound  <= 1'b0;
                        r_emit    <= '0;
                        r_k       <= k_eff;
                        r_best    <= '0;
                        r_win     <= '0;
                        r_o_label <= '0;
                        r_o_count <= '0;
                        r_o_win   <= '0;
                        r_o_last  <= 1'b1;
                        case (i_req.cmd)
                            CMD_ADD: begin
                                r_o_status <= ST_OK;
                                r_state    <= S_SCAN;
                            end
                            CMD_TOPK: begin
                                if (i_req.top_k == '0 || r_n == '0) begin
                                    r_o_status <= ST_EMPTY;
                                    r_state    <= S_OUT;
                                end else begin
                                    r_o_status <= ST_OK;
                                    r_state    <= S_SCAN;
                                end
                            end
                            CMD_WIN: begin
                                if (r_n == '0) begin
                                    r_o_status <= ST_EMPTY;
                                    r_state    <= S_OUT;
                                end else begin
                                    r_o_status <= ST_OK;
                                    r_state    <= S_SCAN;
                                end
                            end
                            default: begin
                                r_o_status <= ST_OK;
                                r_n        <= '0;
                                r_state    <= S_OUT;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (issue) begin
                        r_ptr  <= r_ptr + 1'b1;
                        r_pv   <= 1'b1;
                        r_pidx <= r_ptr[AW-1:0];
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv) begin
                        case (r_op)
                            CMD_ADD: begin
                                if (match) begin
                                    r_o_count <= cnt_inc;
                                    r_state   <= S_OUT;
                                end
                            end
                            CMD_TOPK: begin
                                if (better) begin
                                    r_bfound <= 1'b1;
                                    r_bcnt   <= r_cnt_rd;
                                    r_bidx   <= r_pidx;
                                end
                            end
                            default: begin
                                if (r_cnt_rd > r_best) begin
                                    r_best <= r_cnt_rd;
                                    r_win  <= 7'd1;
                                end else if (r_cnt_rd == r_best) begin
                                    r_win <= r_win + 7'd1;
                                end
                            end
                        endcase
                    end
                    if (scan_done) begin
                        case (r_op)
                            CMD_ADD: begin
                                if (r_n == CW'(DEPTH)) begin
                                    r_o_status <= ST_FULL;
                                end else begin
                                    r_n       <= r_n + 1'b1;
                                    r_o_count <= 32'd1;
                                end
                                r_state <= S_OUT;
                            end
                            CMD_TOPK: r_state <= S_FETCH;
                            default: begin
                                r_o_win <= r_win;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_FETCH: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_o_label  <= r_lbl_rd;
                    r_o_count  <= r_bcnt;
                    r_o_status <= ST_OK;
                    r_o_last   <= (7'(r_emit + 7'd1) == r_k);
                    r_state    <= S_OUT;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        if (r_o_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_emit   <= r_emit + 7'd1;
                            r_first  <= 1'b0;
                            r_pcnt   <= r_bcnt;
                            r_lidx   <= r_bidx;
                            r_bfound <= 1'b0;
                            r_ptr    <= '0;
                            r_pv     <= 1'b0;
                            r_state  <= S_SCAN;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `VFC_ASSERT(a_n_bound, i_clk, i_rst_n, r_n <= CW'(DEPTH), "entry count beyond depth")
    `VFC_ASSERT_IMP(a_full_only_at_depth, i_clk, i_rst_n, o_valid && r_o_status == ST_FULL, r_n == CW'(DEPTH), "full status below depth")
    `VFC_ASSERT_IMP(a_topk_found, i_clk, i_rst_n, r_state == S_FETCH, r_bfound && r_op == CMD_TOPK, "top k walk found no entry")
    `VFC_ASSERT_IMP(a_append_grows, i_clk, i_rst_n, append, ##1 (r_n == $past(r_n) + 1'b1), "append did not grow table")

endmodule

FILE: rtl/value_frequency_counter_topk.sv
// value frequency counter with top k report: a label/count table walked by a
// single engine. Add, top k and winner walk the stored entries one per cycle
// through the table memory's read port; an add that hits ends at its entry,
// and each top k result takes a walk of its own. Clear does not walk. Up to
// two words queue ahead of the engine, so the input keeps being taken while
// a result waits on stall, until the queue is full.
// +0 and -0 match, a NaN never matches, counts saturate at all ones, and an
// add that misses on a full table is dropped with status full.
// depends on vfc_pkg, vfc_front, vfc_back
module value_frequency_counter_topk import vfc_pkg::*; #(
    parameter int DEPTH = TABLE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input word channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [63:0] i_label,
    input  logic [6:0]  i_top_k,
    // result word channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_out_label,
    output logic [31:0] o_out_count,
    output logic [6:0]  o_winners,
    output logic [1:0]  o_status,
    output logic        o_last
);

    t_req req;
    logic req_valid;
    logic req_pop;

    // front: classify label (nan, zero) and queue the request
    vfc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .i_label     (i_label),
        .i_top_k     (i_top_k),
        .o_req       (req),
        .o_req_valid (req_valid),
        .i_req_pop   (req_pop)
    );

    // back: table memories and the walk engine
    vfc_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_req_valid (req_valid),
        .o_req_pop   (req_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_label (o_out_label),
        .o_out_count (o_out_count),
        .o_winners   (o_winners),
        .o_status    (o_status),
        .o_last      (o_last)
    );

endmodule
